>>> sv/avf_pkg.sv
// Shared types and constants for the articulation vertex finder.
// Used by the front end, the back end and the top level. No dependencies.
package avf_pkg;

  // Graph size limits and field widths.
  localparam int MAX_VERTICES = 64;
  localparam int ROW_W        = MAX_VERTICES;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = 2;

  // Request type codes on the input channel.
  localparam logic [1:0] REQ_EDGE  = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Result kind codes.
  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Classified operation held in the queue.
  typedef enum logic [1:0] {
    OP_EDGE,
    OP_RUN,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] end_a;
    logic [IDX_W-1:0] end_b;
    logic [CNT_W-1:0] vcount;
  } qitem_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic   valid;
    qitem_t item;
  } qhead_t;

endpackage

>>> sv/avf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module avf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/avf_front.sv
// Front end: holds the vertex count register, classifies requests and
// queues them for the back end. Depends on avf_pkg.
module avf_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            req_type,
  input  logic [5:0]            end_a,
  input  logic [5:0]            end_b,
  input  logic                  cfg_write,
  input  logic [6:0]            cfg_data,
  input  logic                  pop,
  output avf_pkg::qhead_t       head
);
  import avf_pkg::*;

  logic [CNT_W-1:0]  vertex_count;
  logic [CNT_W-1:0]  n_eff;
  logic              keep;
  logic              push;
  qitem_t            item;
  qitem_t            queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  // Effective vertex count saturates at the maximum.
  assign n_eff = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                      : vertex_count;

  // Classify the request; out-of-range edges and unused codes are dropped.
  always_comb begin
    item.end_a  = end_a;
    item.end_b  = end_b;
    item.vcount = n_eff;
    item.op     = OP_EDGE;
    keep        = 1'b0;
    case (req_type)
      REQ_EDGE: begin
        item.op = OP_EDGE;
        keep    = ({1'b0, end_a} < n_eff) && ({1'b0, end_b} < n_eff);
      end
      REQ_RUN: begin
        item.op = OP_RUN;
        keep    = 1'b1;
      end
      REQ_CLEAR: begin
        item.op = OP_CLEAR;
        keep    = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy       = (count == (QPTR_W+1)'(QDEPTH));
  assign push       = start && !busy && keep;
  assign head.valid = (count != '0);
  assign head.item  = queue[rd_ptr];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CNT_W'(MAX_VERTICES);
    end else if (cfg_write) begin
      vertex_count <= cfg_data;
    end
  end

  // Queue storage and pointers.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  // The back end only takes an entry that is there.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");

  // A transfer into a full queue never happens.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> count < (QPTR_W+1)'(QDEPTH))
    else $error("queue pushed while full");

  // The fill count tracks a lone push.
  a_count_push: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");

endmodule

>>> sv/avf_back.sv
// Back end: keeps the adjacency matrix, runs the depth-first component
// counts and drives the result ports. Depends on avf_pkg and avf_ram.
module avf_back (
  input  logic                  clk,
  input  logic                  rst,
  input  avf_pkg::qhead_t       head,
  output logic                  pop,
  output logic                  result_strobe,
  output logic                  kind,
  output logic [5:0]            cut_vertex,
  output logic [6:0]            component_total,
  output logic [6:0]            cut_total,
  output logic                  is_last
);
  import avf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_A,
    S_EDGE_B,
    S_PASS_INIT,
    S_SCAN,
    S_POP,
    S_STK_RD,
    S_ADJ,
    S_PUSH,
    S_PASS_END,
    S_SUMMARY
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] cur_a;
  logic [IDX_W-1:0] cur_b;
  logic [CNT_W-1:0] n;
  logic             skip;
  logic [IDX_W-1:0] removed_vertex;
  logic [ROW_W-1:0] visited_mask;
  logic [ROW_W-1:0] nb;
  logic [CNT_W-1:0] v;
  logic [CNT_W-1:0] stack_depth;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] base_components;
  logic [CNT_W-1:0] cuts;
  logic [ROW_W-1:0] row_valid;
  logic             rvalid_q;

  logic             adj_we;
  logic [IDX_W-1:0] adj_waddr;
  logic [ROW_W-1:0] adj_wdata;
  logic [IDX_W-1:0] adj_raddr;
  logic [ROW_W-1:0] adj_rdata;
  logic [ROW_W-1:0] row_eff;
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr;
  logic [IDX_W-1:0] stk_wdata;
  logic [IDX_W-1:0] stk_raddr;
  logic [IDX_W-1:0] stk_rdata;
  logic [ROW_W-1:0] live;
  logic [IDX_W-1:0] low_idx;
  logic [CNT_W-1:0] depth_dec;
  logic             scan_new;

  // Adjacency rows and the search stack.
  avf_ram #(.WIDTH(ROW_W), .DEPTH(MAX_VERTICES)) u_adj (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  avf_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VERTICES)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // A row that was never written since the last clear reads as empty.
  assign row_eff = rvalid_q ? adj_rdata : '0;

  // Vertices at or above the count are masked out of every search.
  assign live = (n >= CNT_W'(MAX_VERTICES)) ? '1
              : ((ROW_W'(1) << n[IDX_W-1:0]) - ROW_W'(1));

  // Lowest set bit of the pending neighbor set.
  always_comb begin
    low_idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (nb[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  assign depth_dec = stack_depth - 1'b1;
  assign scan_new  = (v != n) && !visited_mask[v[IDX_W-1:0]];
  assign pop       = (state == S_IDLE) && head.valid;

  // Adjacency read address follows the state.
  always_comb begin
    case (state)
      S_IDLE:   adj_raddr = head.item.end_a;
      S_EDGE_A: adj_raddr = cur_b;
      S_STK_RD: adj_raddr = stk_rdata;
      default:  adj_raddr = '0;
    endcase
  end

  // Adjacency writes set one bit of each endpoint's row.
  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = cur_a;
    adj_wdata = row_eff | (ROW_W'(1) << cur_b);
    if (state == S_EDGE_A) begin
      adj_we = 1'b1;
    end else if (state == S_EDGE_B) begin
      adj_we    = (cur_a != cur_b);
      adj_waddr = cur_b;
      adj_wdata = row_eff | (ROW_W'(1) << cur_a);
    end
  end

  // Stack pushes come from a new root or from a neighbor.
  assign stk_we    = ((state == S_SCAN) && scan_new) || ((state == S_PUSH) && (nb != '0));
  assign stk_waddr = (state == S_SCAN) ? '0 : stack_depth[IDX_W-1:0];
  assign stk_wdata = (state == S_SCAN) ? v[IDX_W-1:0] : low_idx;
  assign stk_raddr = depth_dec[IDX_W-1:0];

  // Sequencer with registered result outputs.
  always_ff @(posedge clk) begin
    rvalid_q <= row_valid[adj_raddr];
    if (rst) begin
      state         <= S_IDLE;
      row_valid     <= '0;
      result_strobe <= 1'b0;
      stack_depth   <= '0;
      skip          <= 1'b0;
      v             <= '0;
      count         <= '0;
      cuts          <= '0;
    end else begin
      // A result goes out for a cut found at the end of a pass and for the summary.
      result_strobe <= (state == S_SUMMARY) ||
                       ((state == S_PASS_END) && skip && (count > base_components));
      if (adj_we) begin
        row_valid[adj_waddr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            cur_a <= head.item.end_a;
            cur_b <= head.item.end_b;
            n     <= head.item.vcount;
            case (head.item.op)
              OP_EDGE: begin
                state <= S_EDGE_A;
              end
              OP_RUN: begin
                skip           <= 1'b0;
                removed_vertex <= '0;
                cuts           <= '0;
                state          <= S_PASS_INIT;
              end
              default: begin
                row_valid <= '0;
              end
            endcase
          end
        end
        S_EDGE_A: begin
          state <= S_EDGE_B;
        end
        S_EDGE_B: begin
          state <= S_IDLE;
        end
        S_PASS_INIT: begin
          visited_mask <= skip ? (ROW_W'(1) << removed_vertex) : '0;
          v            <= '0;
          count        <= '0;
          stack_depth  <= '0;
          state        <= S_SCAN;
        end
        S_SCAN: begin
          if (v == n) begin
            state <= S_PASS_END;
          end else if (!scan_new) begin
            v <= v + 1'b1;
          end else begin
            count                           <= count + 1'b1;
            visited_mask[v[IDX_W-1:0]]      <= 1'b1;
            stack_depth                     <= CNT_W'(1);
            state                           <= S_POP;
          end
        end
        S_POP: begin
          if (stack_depth == '0) begin
            v     <= v + 1'b1;
            state <= S_SCAN;
          end else begin
            stack_depth <= depth_dec;
            state       <= S_STK_RD;
          end
        end
        S_STK_RD: begin
          state <= S_ADJ;
        end
        S_ADJ: begin
          nb    <= row_eff & live & ~visited_mask;
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (nb == '0) begin
            state <= S_POP;
          end else begin
            visited_mask[low_idx] <= 1'b1;
            stack_depth           <= stack_depth + 1'b1;
            nb                    <= nb & (nb - ROW_W'(1));
          end
        end
        S_PASS_END: begin
          if (!skip) begin
            base_components <= count;
            skip            <= 1'b1;
            removed_vertex  <= '0;
            state           <= (n == '0) ? S_SUMMARY : S_PASS_INIT;
          end else begin
            if (count > base_components) begin
              kind            <= KIND_REPORT;
              cut_vertex      <= removed_vertex;
              component_total <= '0;
              cut_total       <= '0;
              is_last         <= 1'b0;
              cuts            <= cuts + 1'b1;
            end
            if (({1'b0, removed_vertex} + CNT_W'(1)) == n) begin
              state <= S_SUMMARY;
            end else begin
              removed_vertex <= removed_vertex + 1'b1;
              state          <= S_PASS_INIT;
            end
          end
        end
        S_SUMMARY: begin
          kind            <= KIND_SUMMARY;
          cut_vertex      <= '0;
          component_total <= base_components;
          cut_total       <= cuts;
          is_last         <= 1'b1;
          state           <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Results only come out of the end of a pass or the summary step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> ($past(state) == S_PASS_END || $past(state) == S_SUMMARY))
    else $error("result transfer from an unexpected state");

  // Every vertex is pushed at most once per pass.
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    stack_depth <= CNT_W'(MAX_VERTICES))
    else $error("search stack overflow");

  // The root scan never runs past the vertex count.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> v <= n)
    else $error("root scan beyond vertex count");

  // After the summary transfer the back end is ready for the next entry.
  a_summary_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe && is_last |-> state == S_IDLE)
    else $error("summary without return to idle");

endmodule

>>> sv/articulation_vertex_finder_top.sv
// Articulation vertex finder, top level.
// Instantiates avf_front and avf_back; depends on avf_pkg.
//
// Usage: a request is transferred at a rising edge with start high and busy
// low. req_type selects add edge (end_a, end_b), run analysis or clear graph.
// The front end queues up to four requests, so edge loads are taken every
// cycle until the queue fills; the back end retires an edge by reading a row,
// writing the first row and writing the second row, and a clear at its pop.
// A run counts components of the whole graph by depth-first search, then
// once more with each vertex removed in turn. Each pass is a root scan and
// bookkeeping plus, per visited vertex, a stack pop, a stack read, an
// adjacency read and neighbor pushes, paced by the single adjacency read
// port and the stack RAM round trip. Each cut vertex is reported on
// result_strobe for one cycle as soon as its pass ends, and the summary
// (is_last high) is strobed in the cycle after the last pass's report slot.
// The receiver cannot stall: every strobed result is a transfer. Reset
// empties the graph (per-row valid bits), clears the queue and sets
// vertex_count to 64. cfg_write loads vertex_count; it is to be used only
// while idle, by the user: the block itself does not enforce this.
module articulation_vertex_finder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type,
  input  logic [5:0] end_a,
  input  logic [5:0] end_b,
  input  logic       cfg_write,
  input  logic [6:0] cfg_data,
  output logic       result_strobe,
  output logic       kind,
  output logic [5:0] cut_vertex,
  output logic [6:0] component_total,
  output logic [6:0] cut_total,
  output logic       is_last
);
  import avf_pkg::*;

  qhead_t head;
  logic   pop;

  // Request classification and queue.
  avf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .end_a     (end_a),
    .end_b     (end_b),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .pop       (pop),
    .head      (head)
  );

  // Graph storage, searches and results.
  avf_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .pop             (pop),
    .result_strobe   (result_strobe),
    .kind            (kind),
    .cut_vertex      (cut_vertex),
    .component_total (component_total),
    .cut_total       (cut_total),
    .is_last         (is_last)
  );

endmodule

>>> dv/articulation_vertex_finder_top_test.sv
// Self-checking testbench for articulation_vertex_finder_top.
// Depends on avf_pkg and the RTL only. A directed table runs first, then random graph phases.
// An in-bench graph predictor checks every strobed result.
module articulation_vertex_finder_top_test;
  import avf_pkg::*;

  // Request code that the block must ignore.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int ITEM_TARGET    = 160;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int SCRIPT_LEN     = 26;

  // One expected transfer on the result side.
  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] vertex;
    logic [CNT_W-1:0] parts;
    logic [CNT_W-1:0] cuts;
    logic             last;
  } cut_result_t;

  // One row of the directed table. A typed row carries a known summary-only outcome.
  typedef struct packed {
    logic             is_cfg;
    logic [CNT_W-1:0] cfg_value;
    logic [1:0]       req;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic             typed;
    logic [CNT_W-1:0] parts;
    logic [CNT_W-1:0] cuts;
  } script_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       req_type = REQ_EDGE;
  logic [5:0]       end_a = '0;
  logic [5:0]       end_b = '0;
  logic             cfg_write = 1'b0;
  logic [6:0]       cfg_data = '0;
  logic             result_strobe;
  logic             kind;
  logic [5:0]       cut_vertex;
  logic [6:0]       component_total;
  logic [6:0]       cut_total;
  logic             is_last;

  // Predictor state: the adjacency matrix and the vertex count register.
  logic [ROW_W-1:0] graph_rows [MAX_VERTICES];
  logic [CNT_W-1:0] vertex_limit = 7'd64;

  cut_result_t pending_results [$];
  script_row_t script_rows [SCRIPT_LEN];
  int          mismatches = 0;
  int          applied_items = 0;
  int          quiet_cycles = 0;

  articulation_vertex_finder_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .req_type        (req_type),
    .end_a           (end_a),
    .end_b           (end_b),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .result_strobe   (result_strobe),
    .kind            (kind),
    .cut_vertex      (cut_vertex),
    .component_total (component_total),
    .cut_total       (cut_total),
    .is_last         (is_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Vertices in use: the register saturated at the matrix size.
  function automatic int unsigned live_vertices();
    return (vertex_limit > MAX_VERTICES) ? MAX_VERTICES : vertex_limit;
  endfunction

  // Count connected components among vertices below n, optionally with one vertex removed.
  // Edges to vertices at or above n are masked out.
  function automatic int unsigned count_parts(int unsigned n, bit skip_en, int unsigned skip_v);
    logic [ROW_W-1:0] live;
    logic [ROW_W-1:0] seen;
    logic [ROW_W-1:0] fresh;
    int unsigned      parts;
    int unsigned      u;
    int unsigned      v;
    int unsigned      w;
    int unsigned      frontier [$];
    live = (n >= MAX_VERTICES) ? '1 : ((64'd1 << n) - 64'd1);
    seen = '0;
    if (skip_en) seen[skip_v] = 1'b1;
    parts = 0;
    for (v = 0; v < n; v++) begin
      if (!seen[v]) begin
        parts++;
        seen[v] = 1'b1;
        frontier.push_front(v);
        while (frontier.size() != 0) begin
          u = frontier.pop_front();
          fresh = graph_rows[u] & live & ~seen;
          seen |= fresh;
          for (w = 0; w < MAX_VERTICES; w++) begin
            if (fresh[w]) frontier.push_front(w);
          end
        end
      end
    end
    return parts;
  endfunction

  // Work out the cut vertex reports and the summary of one analysis run.
  function automatic void predict_cut_vertices();
    int unsigned n;
    int unsigned base;
    int unsigned cuts;
    int unsigned v;
    cut_result_t r;
    n = live_vertices();
    base = count_parts(n, 1'b0, 0);
    cuts = 0;
    for (v = 0; v < n; v++) begin
      if (count_parts(n, 1'b1, v) > base) begin
        r = '{kind: KIND_REPORT, vertex: v[IDX_W-1:0], parts: '0, cuts: '0, last: 1'b0};
        pending_results.insert(pending_results.size(), r);
        cuts++;
      end
    end
    r = '{kind: KIND_SUMMARY, vertex: '0, parts: base[CNT_W-1:0], cuts: cuts[CNT_W-1:0],
          last: 1'b1};
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Apply one accepted request to the graph and queue what it should produce.
  // Returns whether the request had any effect on the block.
  function automatic bit apply_request(logic [1:0] req, logic [5:0] a, logic [5:0] b,
                                       bit typed, logic [6:0] t_parts, logic [6:0] t_cuts);
    int unsigned n;
    cut_result_t r;
    n = live_vertices();
    case (req)
      REQ_EDGE: begin
        if (a < n && b < n) begin
          graph_rows[a][b] = 1'b1;
          graph_rows[b][a] = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      REQ_CLEAR: begin
        foreach (graph_rows[i]) graph_rows[i] = '0;
        return 1'b1;
      end
      REQ_RUN: begin
        if (typed) begin
          r = '{kind: KIND_SUMMARY, vertex: '0, parts: t_parts, cuts: t_cuts, last: 1'b1};
          pending_results.insert(pending_results.size(), r);
        end else begin
          predict_cut_vertices();
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Present one request, hold it until the transfer, then, if gaps is set, wait a random gap.
  task automatic send_request(logic [1:0] req, logic [5:0] a, logic [5:0] b, bit gaps,
                              bit typed = 1'b0, logic [6:0] t_parts = '0,
                              logic [6:0] t_cuts = '0);
    int gap;
    start    <= 1'b1;
    req_type <= req;
    end_a    <= a;
    end_b    <= b;
    do @(posedge clk); while (busy);
    if (apply_request(req, a, b, typed, t_parts, t_cuts)) applied_items++;
    gap = gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Write vertex_count once all results are in and the queued edges have retired.
  task automatic set_vertex_limit(logic [6:0] value);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    vertex_limit = value;
  endtask

  // Result checker: every strobe is a transfer and must match the oldest expectation.
  always @(posedge clk) begin
    cut_result_t want;
    if (!rst && result_strobe) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d, cut_vertex %0d, is_last %0d",
               kind, cut_vertex, is_last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, kind);
          mismatches++;
        end
        if (cut_vertex !== want.vertex) begin
          $error("cut_vertex: expected %0d, actual %0d", want.vertex, cut_vertex);
          mismatches++;
        end
        if (component_total !== want.parts) begin
          $error("component_total: expected %0d, actual %0d", want.parts, component_total);
          mismatches++;
        end
        if (cut_total !== want.cuts) begin
          $error("cut_total: expected %0d, actual %0d", want.cuts, cut_total);
          mismatches++;
        end
        if (is_last !== want.last) begin
          $error("is_last: expected %0d, actual %0d", want.last, is_last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned parent;
    int unsigned extra;
    int unsigned u;
    int unsigned v;
    int          big_phases;
    int          pick;
    bit          gaps;
    logic [5:0]  a;
    logic [5:0]  b;
    logic [6:0]  count_value;

    foreach (graph_rows[i]) graph_rows[i] = '0;

    // Directed table: extremes, self loops, ignored requests, count limits and stale edges.
    script_rows = '{
      '{1'b0, 7'd0,   REQ_RUN,    6'd0,  6'd0,  1'b1, 7'd64, 7'd0},
      '{1'b0, 7'd0,   REQ_EDGE,   6'd0,  6'd63, 1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_EDGE,   6'd63, 6'd63, 1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_EDGE,   6'd0,  6'd1,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_RUN,    6'd0,  6'd0,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_UNUSED, 6'd63, 6'd0,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_CLEAR,  6'd63, 6'd63, 1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_RUN,    6'd0,  6'd0,  1'b1, 7'd64, 7'd0},
      '{1'b1, 7'd1,   REQ_EDGE,   6'd0,  6'd0,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_EDGE,   6'd0,  6'd0,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_EDGE,   6'd1,  6'd0,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_RUN,    6'd0,  6'd0,  1'b1, 7'd1,  7'd0},
      '{1'b1, 7'd0,   REQ_EDGE,   6'd0,  6'd0,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_EDGE,   6'd0,  6'd0,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_RUN,    6'd0,  6'd0,  1'b1, 7'd0,  7'd0},
      '{1'b1, 7'd127, REQ_EDGE,   6'd0,  6'd0,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_EDGE,   6'd2,  6'd3,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_EDGE,   6'd3,  6'd4,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_RUN,    6'd0,  6'd0,  1'b0, 7'd0,  7'd0},
      '{1'b1, 7'd4,   REQ_EDGE,   6'd0,  6'd0,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_RUN,    6'd0,  6'd0,  1'b1, 7'd3,  7'd0},
      '{1'b0, 7'd0,   REQ_EDGE,   6'd0,  6'd1,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_EDGE,   6'd1,  6'd2,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_EDGE,   6'd5,  6'd2,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_RUN,    6'd0,  6'd0,  1'b0, 7'd0,  7'd0},
      '{1'b0, 7'd0,   REQ_CLEAR,  6'd0,  6'd0,  1'b0, 7'd0,  7'd0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (script_rows[i].is_cfg) begin
        set_vertex_limit(script_rows[i].cfg_value);
      end else begin
        send_request(script_rows[i].req, script_rows[i].a, script_rows[i].b, 1'b1,
                     script_rows[i].typed, script_rows[i].parts, script_rows[i].cuts);
      end
    end

    // Random phases: set a count, build a graph with some noise, then analyze it.
    big_phases = 0;
    while (applied_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0 && big_phases < 2) begin
        count_value = ($urandom_range(0, 1) == 0) ? 7'd64 : 7'($urandom_range(65, 127));
        big_phases++;
      end else if (pick == 1) begin
        count_value = 7'($urandom_range(0, 2));
      end else begin
        count_value = 7'($urandom_range(3, 14));
      end
      set_vertex_limit(count_value);
      n = live_vertices();
      gaps = ($urandom_range(0, 3) != 0);

      // Usually start from an empty graph; otherwise stale edges stay in the matrix.
      if ($urandom_range(0, 3) != 0) send_request(REQ_CLEAR, 6'($urandom), 6'($urandom), gaps);

      if (n <= 16) begin
        // A random spanning tree, sometimes broken, plus a few chords.
        for (v = 1; v < n; v++) begin
          if ($urandom_range(0, 7) == 0) begin
            if (n < MAX_VERTICES)
              send_request(REQ_EDGE, 6'($urandom_range(n, 63)), 6'($urandom), gaps);
            else
              send_request(REQ_UNUSED, 6'($urandom), 6'($urandom), gaps);
          end
          if ($urandom_range(0, 9) != 0) begin
            parent = $urandom_range(0, v - 1);
            if ($urandom_range(0, 1) == 0)
              send_request(REQ_EDGE, 6'(v), 6'(parent), gaps);
            else
              send_request(REQ_EDGE, 6'(parent), 6'(v), gaps);
          end
          if ($urandom_range(0, 19) == 0) send_request(REQ_RUN, '0, '0, gaps);
        end
        extra = (n > 2) ? $urandom_range(0, n / 3) : 0;
      end else begin
        // Sparse edges across the whole range so that high vertex numbers appear.
        extra = $urandom_range(8, 20);
      end

      repeat (extra) begin
        u = $urandom_range(0, (n > 0) ? n - 1 : 0);
        v = ($urandom_range(0, 3) == 0 && n > 0) ? n - 1 : $urandom_range(0, (n > 0) ? n - 1 : 0);
        a = 6'(u);
        b = 6'(v);
        if ($urandom_range(0, 7) == 0) send_request(REQ_UNUSED, 6'($urandom), 6'($urandom), gaps);
        send_request(REQ_EDGE, a, b, gaps);
      end

      send_request(REQ_RUN, 6'($urandom), 6'($urandom), gaps);
      if ($urandom_range(0, 7) == 0) send_request(REQ_RUN, '0, '0, gaps);
    end

    // Drain: every expected result must arrive, then let the pipeline settle.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
